[src/sce_pkg.sv]
// ----------------------------------------------------------------------------
// Sector charge estimator package
// Shared widths, constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int SECI_W = 8;
  localparam int CHG_W  = 12;
  localparam int Q4_W   = 16;
  localparam int MODE_W = 11;
  localparam int RC_W   = 10;

  // Charge levels covered by the level histogram.
  localparam int LVL_W = CHG_W;
  localparam int LVL   = 1 << LVL_W;

  // Bin width of the mode histogram and the Q.4 encoding of bin centers.
  localparam int BIN_SPAN = 5;
  localparam int MODE_STEP = 80;
  localparam int MODE_OFS  = 40;

  // floor(x/10) == (x*52429) >> 19 for every x the batch size can produce.
  localparam int RECIP10    = 52429;
  localparam int RECIP10_SH = 19;
  localparam int KEEP_NUM   = 7;

  // Configuration register indexes.
  localparam logic REG_MIN_CHARGE  = 1'b0;
  localparam logic REG_RESET_COUNT = 1'b1;

  typedef struct packed {
    logic in_load;
    logic cnt_rd;
    logic append;
    logic st_rd;
    logic hist_rd;
    logic hist_inc;
    logic sweep_start;
    logic clear;
    logic div_start;
    logic div_sel;
    logic out_load;
  } sce_cmd_t;

  typedef struct packed {
    logic keep;
    logic batch_full;
    logic hist_last;
    logic clr_done;
    logic sweep_done;
    logic div_done;
    logic out_free;
  } sce_status_t;

endpackage

[src/sce_div.sv]
// ----------------------------------------------------------------------------
// Sector charge estimator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sce_div #(
  parameter int DVD_W = 27,
  parameter int DSR_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W:0]   shift_rem;
  logic             ge;

  assign shift_rem = {rem_q, quo_q[DVD_W-1]};
  assign ge        = shift_rem >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DSR_W'(shift_rem - {1'b0, divisor_i}) : DSR_W'(shift_rem);
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/sce_datapath.sv]
// ----------------------------------------------------------------------------
// Sector charge estimator datapath
// Sample store, counts, level histogram, sorted-sum sweep, divider, result.
// ----------------------------------------------------------------------------
module sce_datapath #(
  parameter int NUM_SECTORS = 256,
  parameter int MAX_SAMPLES = 1024,
  parameter int BIN_COUNT   = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sce_pkg::sce_cmd_t           cmd_i,
  output sce_pkg::sce_status_t        status_o,
  input  logic [sce_pkg::SECI_W-1:0]  sector_i,
  input  logic [sce_pkg::CHG_W-1:0]   charge_i,
  input  logic [sce_pkg::CHG_W-1:0]   min_charge_i,
  input  logic [sce_pkg::RC_W-1:0]    reset_count_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [sce_pkg::SECI_W-1:0]  sector_out_o,
  output logic [sce_pkg::Q4_W-1:0]    centre_mean_q4_o,
  output logic [sce_pkg::Q4_W-1:0]    low_mean_q4_o,
  output logic [sce_pkg::MODE_W-1:0]  binned_mode_q4_o
);
  import sce_pkg::*;

  localparam int SEC_AW  = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int SLOT_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = CHG_W + CNT_W;
  localparam int DVD_W   = SUM_W + 4;
  localparam int BIN_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int STORE_D = NUM_SECTORS << SLOT_W;

  // Append path.
  logic [SECI_W-1:0]  sec_q;
  logic [CHG_W-1:0]   chg_q;
  logic [SEC_AW-1:0]  sec_idx;
  logic [CNT_W-1:0]   cnt_mem [NUM_SECTORS];
  logic [NUM_SECTORS-1:0] cnt_vld_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic [CNT_W-1:0]   n_old, n_clamp, n_new, n_q;
  logic               full;
  logic [CHG_W-1:0]   store_mem [STORE_D];
  logic [CHG_W-1:0]   st_rd_q;
  logic [CNT_W-1:0]   idx_q;

  // Batch sizes.
  logic [31:0]        u7;
  logic [CNT_W-1:0]   used_q;
  logic [CNT_W-1:0]   k_q [3];

  // Histogram and sweep.
  logic [CNT_W-1:0]   hist_mem [LVL];
  logic [CNT_W-1:0]   hist_rd_q;
  logic [LVL_W-1:0]   clr_addr_q;
  logic               sw_run_q, rd_vld_q, mac_vld_q, last_q;
  logic [LVL_W-1:0]   sw_addr_q, pv_q, mac_lvl_q;
  logic [CNT_W-1:0]   cum_q, cum_nx;
  logic               fin;
  logic [CNT_W-1:0]   take [3];
  logic [CNT_W-1:0]   take_q [3];
  logic [SUM_W-1:0]   sum_q [3];
  logic [2:0]         mod5_q;
  logic [LVL_W-1:0]   bin_q;
  logic [CNT_W-1:0]   bacc_q, bmax_q, btot;
  logic [BIN_W-1:0]   maxbin_q;

  // Division and result.
  logic [DVD_W-1:0]   dvd;
  logic               div_done;
  logic [DVD_W-1:0]   quo;
  logic [Q4_W-1:0]    q16;
  logic [Q4_W-1:0]    centre_q, low_q;
  logic               out_vld_q;
  logic [SECI_W-1:0]  o_sec_q;
  logic [Q4_W-1:0]    o_centre_q, o_low_q;
  logic [MODE_W-1:0]  o_mode_q;

  assign sec_idx = SEC_AW'(sec_q);
  assign n_old   = cnt_vld_q[sec_idx] ? cnt_rd_q : '0;
  assign n_clamp = (32'(n_old) >= MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES - 1) : n_old;
  assign n_new   = n_clamp + 1'b1;
  assign full    = (32'(n_new) > 32'(reset_count_i)) || (32'(n_new) >= MAX_SAMPLES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      sec_q <= sector_i;
      chg_q <= charge_i;
    end
    if (cmd_i.cnt_rd) cnt_rd_q <= cnt_mem[sec_idx];
    if (cmd_i.append) begin
      cnt_mem[sec_idx] <= full ? '0 : n_new;
      n_q <= n_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.append) begin
      cnt_vld_q[sec_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) store_mem[{sec_idx, SLOT_W'(n_clamp)}] <= chg_q;
    if (cmd_i.st_rd)  st_rd_q <= store_mem[{sec_idx, SLOT_W'(idx_q)}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append)        idx_q <= '0;
    else if (cmd_i.hist_inc) idx_q <= idx_q + 1'b1;
  end

  // Kept share and window bounds of the batch.
  assign u7 = 32'(n_q) * 32'(KEEP_NUM);

  always_ff @(posedge clk_i) begin
    used_q <= CNT_W'((u7 * 32'(RECIP10)) >> RECIP10_SH);
    k_q[0] <= (n_q - used_q) >> 1;
    k_q[1] <= ((n_q - used_q) >> 1) + used_q;
    k_q[2] <= used_q;
  end

  // Histogram memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_rd)  hist_rd_q <= hist_mem[st_rd_q];
    else if (sw_run_q)  hist_rd_q <= hist_mem[sw_addr_q];
    if (cmd_i.clear)         hist_mem[clr_addr_q] <= '0;
    else if (cmd_i.hist_inc) hist_mem[st_rd_q] <= hist_rd_q + 1'b1;
    else if (rd_vld_q)       hist_mem[pv_q] <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_addr_q <= '0;
    else if (cmd_i.clear) clr_addr_q <= clr_addr_q + 1'b1;
  end

  // Sweep over charge levels in increasing order.
  assign cum_nx = cum_q + hist_rd_q;
  assign fin    = rd_vld_q && (cum_nx >= n_q);
  assign btot   = bacc_q + hist_rd_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (k_q[k] > cum_q)
        take[k] = ((k_q[k] - cum_q) < hist_rd_q) ? (k_q[k] - cum_q) : hist_rd_q;
      else
        take[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_run_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      mac_vld_q <= 1'b0;
      last_q    <= 1'b0;
    end else if (cmd_i.sweep_start) begin
      sw_run_q  <= 1'b1;
      rd_vld_q  <= 1'b0;
      mac_vld_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (fin) sw_run_q <= 1'b0;
      rd_vld_q  <= sw_run_q && !fin;
      mac_vld_q <= rd_vld_q;
      last_q    <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_start) begin
      sw_addr_q <= '0;
      cum_q     <= '0;
      mod5_q    <= '0;
      bin_q     <= '0;
      bacc_q    <= '0;
      bmax_q    <= '0;
      maxbin_q  <= '0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else begin
      if (sw_run_q) begin
        sw_addr_q <= sw_addr_q + 1'b1;
        pv_q      <= sw_addr_q;
      end
      if (rd_vld_q) begin
        cum_q     <= cum_nx;
        mac_lvl_q <= pv_q;
        for (int k = 0; k < 3; k++) take_q[k] <= take[k];
        if ((32'(bin_q) < BIN_COUNT) && (btot > bmax_q)) begin
          bmax_q   <= btot;
          maxbin_q <= BIN_W'(bin_q);
        end
        if (mod5_q == 3'(BIN_SPAN - 1)) begin
          mod5_q <= '0;
          bin_q  <= bin_q + 1'b1;
          bacc_q <= '0;
        end else begin
          mod5_q <= mod5_q + 1'b1;
          bacc_q <= btot;
        end
      end
      if (mac_vld_q) begin
        for (int k = 0; k < 3; k++)
          sum_q[k] <= sum_q[k] + SUM_W'(take_q[k]) * SUM_W'(mac_lvl_q);
      end
    end
  end

  // Division of the window sums by the kept count.
  assign dvd = cmd_i.div_sel ? {sum_q[2], 4'b0} : {SUM_W'(sum_q[1] - sum_q[0]), 4'b0};

  sce_div #(
    .DVD_W(DVD_W),
    .DSR_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dvd),
    .divisor_i (used_q),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  // An empty window reports zero.
  assign q16 = (used_q == '0) ? '0 : quo[Q4_W-1:0];

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (cmd_i.div_sel) low_q <= q16;
      else               centre_q <= q16;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (cmd_i.out_load) out_vld_q <= 1'b1;
    else if (out_ready_i) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_sec_q    <= sec_q;
      o_centre_q <= centre_q;
      o_low_q    <= low_q;
      o_mode_q   <= MODE_W'(32'(maxbin_q) * MODE_STEP + MODE_OFS);
    end
  end

  assign status_o.keep       = (32'(sector_i) < NUM_SECTORS) && (charge_i > min_charge_i);
  assign status_o.batch_full = full;
  assign status_o.hist_last  = (idx_q + 1'b1) == n_q;
  assign status_o.clr_done   = &clr_addr_q;
  assign status_o.sweep_done = last_q;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o      = out_vld_q;
  assign sector_out_o     = o_sec_q;
  assign centre_mean_q4_o = o_centre_q;
  assign low_mean_q4_o    = o_low_q;
  assign binned_mode_q4_o = o_mode_q;

endmodule

[src/sce_ctrl.sv]
// ----------------------------------------------------------------------------
// Sector charge estimator controller
// Sequences the histogram clear after reset, appends, histogram fill, sweep, divisions and result hand-off.
// ----------------------------------------------------------------------------
module sce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sce_pkg::sce_status_t status_i,
  output sce_pkg::sce_cmd_t    cmd_o
);
  import sce_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CRD    = 4'd2;
  localparam logic [3:0] ST_APPEND = 4'd3;
  localparam logic [3:0] ST_HADDR  = 4'd4;
  localparam logic [3:0] ST_HHRD   = 4'd5;
  localparam logic [3:0] ST_HWR    = 4'd6;
  localparam logic [3:0] ST_SWEEP  = 4'd7;
  localparam logic [3:0] ST_DIVC   = 4'd8;
  localparam logic [3:0] ST_DIVCW  = 4'd9;
  localparam logic [3:0] ST_DIVL   = 4'd10;
  localparam logic [3:0] ST_DIVLW  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_load = in_valid_i;
        if (in_valid_i && status_i.keep) state_d = ST_CRD;
      end
      ST_CRD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d = ST_APPEND;
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d = status_i.batch_full ? ST_HADDR : ST_IDLE;
      end
      ST_HADDR: begin
        cmd_o.st_rd = 1'b1;
        state_d = ST_HHRD;
      end
      ST_HHRD: begin
        cmd_o.hist_rd = 1'b1;
        state_d = ST_HWR;
      end
      ST_HWR: begin
        cmd_o.hist_inc = 1'b1;
        if (status_i.hist_last) begin
          cmd_o.sweep_start = 1'b1;
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_HADDR;
        end
      end
      ST_SWEEP: begin
        if (status_i.sweep_done) state_d = ST_DIVC;
      end
      ST_DIVC: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVCW;
      end
      ST_DIVCW: begin
        if (status_i.div_done) state_d = ST_DIVL;
      end
      ST_DIVL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d = ST_DIVLW;
      end
      ST_DIVLW: begin
        cmd_o.div_sel = 1'b1;
        if (status_i.div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  a_append_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPEND |-> $past(state_q) == ST_CRD)
    else $error("append without a preceding count read");

  a_div_start_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == ST_DIVCW || state_q == ST_DIVLW)
    else $error("division started without a wait state");

  a_sweep_done_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sweep_done |-> state_q == ST_SWEEP)
    else $error("sweep finished outside the sweep state");

endmodule

[src/sector_charge_mpv_estimator.sv]
// ----------------------------------------------------------------------------
// Sector charge estimator
// Per-sector charge batches with truncated means and a binned mode.
// ----------------------------------------------------------------------------
// Flow: a hit passes the idle, count-read and append states, and no new
//   hit is taken before it is appended. A hit that completes a batch also
//   holds the input through the histogram fill, the level sweep, both
//   divisions and the result hand-off.
// Reset: asynchronous, active low; afterward a clearing pass of the level
//   histogram runs while no item is accepted.
module sector_charge_mpv_estimator #(
  parameter int NUM_SECTORS = 256,
  parameter int MAX_SAMPLES = 1024,
  parameter int BIN_COUNT   = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // sector_index[7:0], charge[19:8], zero pad
  // Result item stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // sector_out[7:0], centre_mean_q4[23:8],
                                     // low_mean_q4[39:24], binned_mode_q4[50:40]
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sce_pkg::*;

  sce_cmd_t    cmd;
  sce_status_t status;

  logic [CHG_W-1:0]  min_charge_q;
  logic [RC_W-1:0]   reset_count_q;
  logic              cfg_wr;
  logic [SECI_W-1:0] o_sec;
  logic [Q4_W-1:0]   o_centre, o_low;
  logic [MODE_W-1:0] o_mode;

  // Registers are written in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_charge_q  <= '0;
      reset_count_q <= RC_W'(1000);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_CHARGE:  min_charge_q  <= pwdata[CHG_W-1:0];
        REG_RESET_COUNT: reset_count_q <= pwdata[RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_CHARGE:  prdata = 32'(min_charge_q);
      REG_RESET_COUNT: prdata = 32'(reset_count_q);
      default:         prdata = '0;
    endcase
  end

  // The controller only walks the states; sample, count and histogram storage sits in the datapath.
  sce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sce_datapath #(
    .NUM_SECTORS(NUM_SECTORS),
    .MAX_SAMPLES(MAX_SAMPLES),
    .BIN_COUNT  (BIN_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sector_i        (s_axis_tdata[7:0]),
    .charge_i        (s_axis_tdata[19:8]),
    .min_charge_i    (min_charge_q),
    .reset_count_i   (reset_count_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .sector_out_o    (o_sec),
    .centre_mean_q4_o(o_centre),
    .low_mean_q4_o   (o_low),
    .binned_mode_q4_o(o_mode)
  );

  assign m_axis_tdata = {5'b0, o_mode, o_low, o_centre, o_sec};

endmodule

[tb/sv/sector_charge_mpv_estimator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector charge estimator testbench
// Drives (sector, charge) hits through the input stream and register writes
// through the configuration port. It predicts every completed batch (centered
// and low truncated means, binned mode) and checks each result item against
// the oldest prediction, with random gaps on both streams.
// ----------------------------------------------------------------------------
module sector_charge_mpv_estimator_test;
  import sce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int          SECTORS     = 256;
  localparam int          BINS        = 20;
  localparam logic [2:0]  ADDR_MIN    = 3'(4 * REG_MIN_CHARGE);
  localparam logic [2:0]  ADDR_RC     = 3'(4 * REG_RESET_COUNT);

  // One batch estimate, as it travels on the result stream.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [Q4_W-1:0]   low;
    logic [Q4_W-1:0]   centre;
    logic [SECI_W-1:0] sector;
  } estimate_t;

  // A row of the directed part. Where lit is set, the row completes a batch
  // whose estimate is typed in by hand.
  typedef struct {
    logic [SECI_W-1:0] sec;
    logic [CHG_W-1:0]  chg;
    bit                lit;
    estimate_t         est;
  } hit_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // sector_index[7:0], charge[19:8], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // sector_out[7:0], centre_mean_q4[23:8],
                                    // low_mean_q4[39:24], binned_mode_q4[50:40]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sector_charge_mpv_estimator u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Our own copy of the block's state and registers.
  logic [CHG_W-1:0] batch_samples[SECTORS][$];
  logic [CHG_W-1:0] thr_charge;
  logic [RC_W-1:0]  batch_limit;

  estimate_t   pending_estimates[$];
  int unsigned failures;
  int unsigned hits_sent;
  int unsigned estimates_seen;
  int unsigned reg_writes;
  int unsigned cycles;
  bit          quiet_send;
  bit          stim_done;

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Evaluates a completed batch from its sorted samples.
  function automatic estimate_t estimate_batch(logic [SECI_W-1:0] sec,
                                               logic [CHG_W-1:0] smp[$]);
    int unsigned n, used, first, maxbin;
    longint unsigned low_sum, mid_sum;
    int unsigned bin_hits[BINS];
    estimate_t est;
    smp.sort();
    n = smp.size();
    used = (7 * n) / 10;
    first = (n - used) / 2;
    low_sum = 0;
    mid_sum = 0;
    foreach (bin_hits[b]) bin_hits[b] = 0;
    for (int i = 0; i < n; i++) begin
      if (i < used) low_sum += smp[i];
      if (i >= first && i < first + used) mid_sum += smp[i];
      if (smp[i] / BIN_SPAN < BINS) bin_hits[smp[i] / BIN_SPAN]++;
    end
    maxbin = 0;
    for (int b = 1; b < BINS; b++)
      if (bin_hits[b] > bin_hits[maxbin]) maxbin = b;
    est.sector = sec;
    est.centre = (used == 0) ? '0 : Q4_W'((mid_sum * 16) / used);
    est.low    = (used == 0) ? '0 : Q4_W'((low_sum * 16) / used);
    est.mode   = MODE_W'(maxbin * MODE_STEP + MODE_OFS);
    return est;
  endfunction

  // Applies one accepted hit to the model state and queues any estimate.
  task automatic absorb_hit(hit_row_t row);
    int unsigned n;
    estimate_t est;
    if (row.chg <= thr_charge) return;
    if (batch_samples[row.sec].size() >= 1024) void'(batch_samples[row.sec].pop_back());
    batch_samples[row.sec] = {batch_samples[row.sec], row.chg};
    n = batch_samples[row.sec].size();
    if (n > batch_limit || n >= 1024) begin
      est = estimate_batch(row.sec, batch_samples[row.sec]);
      batch_samples[row.sec].delete();
      if (row.lit) est = row.est;
      pending_estimates = {pending_estimates, est};
    end
  endtask

  // One register write; the bus idles after the access phase before the task returns.
  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MIN) thr_charge = val[CHG_W-1:0];
    else batch_limit = val[RC_W-1:0];
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Waits until every estimate has arrived, then lets any hit still in the
  // pipeline settle before registers change.
  task automatic drain();
    while (pending_estimates.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned thr, int unsigned lim);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(ADDR_MIN, thr);
    write_reg(ADDR_RC, lim);
  endtask

  // Sends one hit. tvalid stays high from one hit to the next when no gap
  // is drawn, so it never gets two assignments in one step.
  task automatic send_hit(hit_row_t row);
    int unsigned gap;
    gap = quiet_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, row.chg, row.sec};
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_hit(row);
    hits_sent++;
    if (hits_sent % 60 == 0) quiet_send = ~quiet_send;
  endtask

  function automatic hit_row_t plain_hit(logic [SECI_W-1:0] sec, logic [CHG_W-1:0] chg);
    hit_row_t row;
    row.sec = sec;
    row.chg = chg;
    row.lit = 1'b0;
    row.est = '0;
    return row;
  endfunction

  // Random charge: mostly inside the mode bins, sometimes anywhere.
  function automatic logic [CHG_W-1:0] draw_charge();
    if ($urandom_range(0, 9) == 0) return CHG_W'($urandom);
    return CHG_W'($urandom_range(0, 160));
  endfunction

  // Result side: a random stall before each item except in every third run of 40, then the field check.
  initial begin : result_check
    int unsigned gap;
    estimate_t got, want;
    forever begin
      gap = ((estimates_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
      got = m_axis_tdata[50:0];
      estimates_seen++;
      if (pending_estimates.size() == 0) begin
        $error("unexpected result item: sector %0d", got.sector);
        failures++;
      end else begin
        want = pending_estimates.pop_front();
        if (got.sector !== want.sector) begin
          $error("sector_out: expected %0d, got %0d", want.sector, got.sector);
          failures++;
        end
        if (got.centre !== want.centre) begin
          $error("centre_mean_q4: expected %0d, got %0d", want.centre, got.centre);
          failures++;
        end
        if (got.low !== want.low) begin
          $error("low_mean_q4: expected %0d, got %0d", want.low, got.low);
          failures++;
        end
        if (got.mode !== want.mode) begin
          $error("binned_mode_q4: expected %0d, got %0d", want.mode, got.mode);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    static hit_row_t directed[] = '{
      '{8'd0,   12'd4095, 1'b0, '0},
      '{8'd0,   12'd4095, 1'b1, '{11'd40, 16'd65520, 16'd65520, 8'd0}},
      '{8'd255, 12'd1,    1'b0, '0},
      '{8'd255, 12'd1,    1'b1, '{11'd40, 16'd16, 16'd16, 8'd255}},
      '{8'd3,   12'd99,   1'b0, '0},
      '{8'd3,   12'd99,   1'b1, '{11'd1560, 16'd1584, 16'd1584, 8'd3}},
      '{8'd4,   12'd9,    1'b0, '0},
      '{8'd4,   12'd9,    1'b1, '{11'd120, 16'd144, 16'd144, 8'd4}},
      '{8'd7,   12'd0,    1'b0, '0},
      '{8'd8,   12'd0,    1'b0, '0},
      '{8'd8,   12'd100,  1'b0, '0},
      '{8'd8,   12'd3,    1'b0, '0},
      '{8'd170, 12'd2730, 1'b0, '0},
      '{8'd170, 12'd1365, 1'b0, '0},
      '{8'd85,  12'd24,   1'b0, '0},
      '{8'd85,  12'd25,   1'b0, '0}
    };
    logic [SECI_W-1:0] hot[4];
    logic [SECI_W-1:0] sec;
    thr_charge  = '0;
    batch_limit = RC_W'(1000);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pairs of hits: each second kept hit closes a batch of two; charge zero is not kept.
    configure(0, 1);
    foreach (directed[i]) send_hit(directed[i]);

    // Batch limit lowered while a batch holds six samples: the next hit closes it
    // with more samples than the new limit allows.
    configure(0, 20);
    for (int i = 0; i < 6; i++) send_hit(plain_hit(8'd9, CHG_W'(100 + 7 * i)));
    configure(0, 2);
    send_hit(plain_hit(8'd9, 12'd200));

    // Highest threshold: nothing can be kept.
    configure(4095, 1);
    send_hit(plain_hit(8'd1, 12'd4095));
    send_hit(plain_hit(8'd1, 12'd4095));

    // Random phases, each with its own threshold and batch size. Most hits
    // go to a few sectors so that batches complete often.
    for (int ph = 0; ph < 6; ph++) begin
      configure(ph == 0 ? 0 : $urandom_range(0, 60),
                ph % 3 == 0 ? 1 : $urandom_range(1, 12));
      foreach (hot[k]) hot[k] = SECI_W'($urandom);
      for (int i = 0; i < 60; i++) begin
        sec = ($urandom_range(0, 4) == 0) ? SECI_W'($urandom) : hot[$urandom_range(0, 3)];
        send_hit(plain_hit(sec, draw_charge()));
      end
    end

    // A long batch: one sector collects 201 samples, which closes its batch.
    configure(0, 200);
    sec = SECI_W'($urandom);
    for (int i = 0; i < 201; i++) send_hit(plain_hit(sec, CHG_W'($urandom_range(1, 4095))));
    s_axis_tvalid <= 1'b0;

    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d hits and %0d register writes; %0d estimates arrived.",
             hits_sent, reg_writes, estimates_seen);
    if (pending_estimates.size() > 0) begin
      $error("%0d estimates never arrived", pending_estimates.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
